// ===== rtl/ffpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int FreeSlots = 16;
  localparam int CntW = $clog2(FreeSlots + 1);

  localparam logic [16:0] BlockSizeRst = 17'd4096;
  localparam logic [39:0] StartOffsetRst = 40'd0;

  localparam logic CfgBlockSize = 1'b0;
  localparam logic CfgStartOffset = 1'b1;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree = 1'b1;

  localparam logic [1:0] StAllocated = 2'd0;
  localparam logic [1:0] StFreeStored = 2'd1;
  localparam logic [1:0] StListFull = 2'd2;
  localparam logic [1:0] StExhausted = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] req_size;
    logic [39:0] page_offset;
  } in_item_t;

  typedef struct packed {
    logic [39:0] out_offset;
    logic [31:0] out_size;
    logic        reused;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] size;
    logic [39:0] offset;
  } entry_t;

  // Control from the sequencer to each cell of the list.
  typedef struct packed {
    logic        rotate;   // every cell takes its right neighbour's entry
    logic        append;   // the cell at the write slot loads the new entry
  } cell_ctl_t;

endpackage

// ===== rtl/ffpa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_cell
// One slot of the free list, handing its entry to the left neighbour.
// ----------------------------------------------------------------------------
module ffpa_cell (
  input  logic              clk,
  input  ffpa_pkg::cell_ctl_t ctl,
  input  logic              sel_wr,
  input  ffpa_pkg::entry_t  wr_entry,
  input  ffpa_pkg::entry_t  right_entry,
  output ffpa_pkg::entry_t  entry
);
  import ffpa_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.rotate) begin
      entry_nxt = right_entry;
    end else if (ctl.append && sel_wr) begin
      entry_nxt = wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== rtl/ffpa_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_divider
// Bit-serial restoring division giving the request rounded up to a block.
// ----------------------------------------------------------------------------
module ffpa_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] req,
  input  logic [16:0] bs,
  output logic        done,
  output logic [49:0] rounded
);
  import ffpa_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] num_r, num_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [16:0] bsd_r, bsd_nxt;
  logic [17:0] trial;
  logic [16:0] bs_eff;

  assign bs_eff = (bs == 17'd0) ? 17'd1 : bs;
  assign trial = {rem_r, num_r[32]} - {1'b0, bsd_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    bsd_nxt = bsd_r;
    done = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 6'd0;
      num_nxt = {1'b0, req} + {16'd0, bs_eff} - 33'd1;
      rem_nxt = 17'd0;
      quo_nxt = 33'd0;
      bsd_nxt = bs_eff;
    end else if (busy_r) begin
      num_nxt = {num_r[31:0], 1'b0};
      if (!trial[17]) begin
        rem_nxt = trial[16:0];
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], num_r[32]};
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    bsd_r <= bsd_nxt;
  end

  assign rounded = 50'(quo_nxt) * 50'(bsd_r);

endmodule

// ===== rtl/first_fit_page_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_unit
// First-fit allocator over a rotating chain of free-list cells.
// ----------------------------------------------------------------------------
// A free transaction is answered in the cycle after acceptance. An allocate
// transaction passes through the bit-serial rounding division, whose last
// step also forms the product, then the range check, then the chain of cells
// rotates the list past its head entry by entry, and a closing step follows
// before its result is raised. A request whose rounded size does not fit in
// 32 bits skips the scan. One transaction is handled at a time; the result
// is held in an output register until taken, and no new transaction is
// accepted before then.
module first_fit_page_allocator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffpa_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ffpa_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [39:0]          cfg_wdata
);
  import ffpa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [16:0]     bs_r;
  logic [39:0]     endp_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] step_r, step_nxt;
  logic            found_r, found_nxt;
  logic [49:0]     rnd_r;
  out_item_t       res_r, res_nxt;
  logic            valid_r, valid_nxt;
  logic [39:0]     endp_nxt;

  logic            div_done;
  logic [49:0]     div_rnd;
  logic            div_start;

  cell_ctl_t       ctl;
  entry_t          cells [FreeSlots];
  entry_t          new_entry;
  logic [40:0]     sum;

  assign in_ready = (state_r == S_IDLE) && !valid_r;
  assign div_start = in_valid && in_ready && (in_data.kind == KindAlloc);
  assign sum = {1'b0, endp_r} + {1'b0, rnd_r[39:0]};

  ffpa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .req(in_data.req_size),
    .bs(bs_r), .done(div_done), .rounded(div_rnd)
  );

  // Entry appended on a free, or the head recirculated to the tail in a scan.
  always_comb begin
    if (state_r == S_SCAN) begin
      new_entry = cells[0];
    end else begin
      new_entry.size = in_data.req_size;
      new_entry.offset = in_data.page_offset;
    end
  end

  genvar g;
  generate
    for (g = 0; g < FreeSlots; g++) begin : g_cell
      entry_t right;
      logic   sel;
      if (g == FreeSlots - 1) begin : g_last
        assign right = new_entry;
      end else begin : g_mid
        assign right = (CntW'(g + 1) == count_r) ? new_entry : cells[g + 1];
      end
      assign sel = (CntW'(g) == count_r);
      ffpa_cell u_cell (
        .clk(clk), .ctl(ctl), .sel_wr(sel), .wr_entry(new_entry),
        .right_entry(right), .entry(cells[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt = step_r;
    found_nxt = found_r;
    res_nxt = res_r;
    valid_nxt = valid_r;
    endp_nxt = endp_r;
    ctl = '0;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          res_nxt = '0;
          if (in_data.kind == KindFree) begin
            valid_nxt = 1'b1;
            if (count_r == CntW'(FreeSlots)) begin
              res_nxt.status = StListFull;
            end else begin
              ctl.append = 1'b1;
              count_nxt = count_r + CntW'(1);
              res_nxt.status = StFreeStored;
            end
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        step_nxt = '0;
        found_nxt = 1'b0;
        if (rnd_r > 50'h0_FFFF_FFFF) begin
          res_nxt.status = StExhausted;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step_r == (count_r + CntW'(found_r))) begin
          if (!found_r) begin
            if (sum[40]) begin
              res_nxt.status = StExhausted;
            end else begin
              res_nxt.out_offset = endp_r;
              res_nxt.out_size = rnd_r[31:0];
              res_nxt.status = StAllocated;
              endp_nxt = sum[39:0];
            end
          end
          state_nxt = S_OUT;
        end else begin
          ctl.rotate = 1'b1;
          step_nxt = step_r + CntW'(1);
          if (!found_r && ({18'd0, cells[0].size} >= rnd_r)) begin
            found_nxt = 1'b1;
            res_nxt.out_offset = cells[0].offset;
            res_nxt.out_size = cells[0].size;
            res_nxt.reused = 1'b1;
            res_nxt.status = StAllocated;
            // The taken entry lands in the tail slot, which falls outside the
            // shortened list; the remaining entries rotate over one slot less.
            count_nxt = count_r - CntW'(1);
          end
        end
      end
      S_OUT: begin
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we && cfg_index == CfgStartOffset) begin
      endp_nxt = cfg_wdata;
    end
  end

  // Removal in the chain: once an entry is taken the list rotates on over the
  // shorter ring until every remaining entry is back in its original order.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
      bs_r <= BlockSizeRst;
      endp_r <= StartOffsetRst;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      endp_r <= endp_nxt;
      if (cfg_we && cfg_index == CfgBlockSize) begin
        bs_r <= cfg_wdata[16:0];
      end
    end
    step_r <= step_nxt;
    found_r <= found_nxt;
    res_r <= res_nxt;
    if (div_done) begin
      rnd_r <= div_rnd;
    end
  end

  assign out_valid = valid_r;
  assign out_data = res_r;

endmodule

// ===== tb/first_fit_page_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_unit_test
// Self-checking bench for the first-fit page allocator.
// ----------------------------------------------------------------------------
// A table of directed transactions covers zero and oversized requests, reuse
// of freed entries and a full free list. Random allocate and free traffic
// follows under several register settings, among them the register extremes.
// Each result is compared with the output of a behavioural allocator held here.
module first_fit_page_allocator_unit_test;
  import ffpa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CfgBlockSize;
  logic [39:0] cfg_wdata = '0;

  first_fit_page_allocator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic        kind;
    logic [31:0] req;
    logic [39:0] poff;
    bit          typed;
    out_item_t   res;
  } row_t;

  logic [16:0] gran;
  logic [31:0] list_size [FreeSlots];
  logic [39:0] list_off [FreeSlots];
  int          list_len;
  logic [39:0] carve_ptr;
  out_item_t   expected_q [$];
  int          errors = 0;
  int          quiet = 0;
  bit          no_idle = 1'b0;

  function automatic out_item_t allocate_or_free(in_item_t it);
    out_item_t r;
    logic [63:0] bs, rounded;
    r = '0;
    if (it.kind == KindFree) begin
      if (list_len >= FreeSlots) begin
        r.status = StListFull;
      end else begin
        list_size[list_len] = it.req_size;
        list_off[list_len] = it.page_offset;
        list_len++;
        r.status = StFreeStored;
      end
      return r;
    end
    bs = (gran == 0) ? 64'd1 : {47'd0, gran};
    rounded = (({32'd0, it.req_size} + bs - 1) / bs) * bs;
    if (rounded > 64'hFFFF_FFFF) begin
      r.status = StExhausted;
      return r;
    end
    for (int i = 0; i < list_len; i++) begin
      if ({32'd0, list_size[i]} >= rounded) begin
        r.out_offset = list_off[i];
        r.out_size = list_size[i];
        r.reused = 1'b1;
        r.status = StAllocated;
        for (int j = i; j + 1 < list_len; j++) begin
          list_size[j] = list_size[j + 1];
          list_off[j] = list_off[j + 1];
        end
        list_len--;
        return r;
      end
    end
    if ({24'd0, carve_ptr} + rounded > 64'hFF_FFFF_FFFF) begin
      r.status = StExhausted;
      return r;
    end
    r.out_offset = carve_ptr;
    r.out_size = rounded[31:0];
    r.status = StAllocated;
    carve_ptr = carve_ptr + rounded[39:0];
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [39:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgBlockSize) begin
      gran = val[16:0];
    end else begin
      carve_ptr = val;
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send(logic kind, logic [31:0] req, logic [39:0] poff,
                      bit typed, out_item_t res);
    in_item_t it;
    out_item_t e;
    it.kind = kind;
    it.req_size = req;
    it.page_offset = poff;
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = allocate_or_free(it);
    if (typed && e != res) begin
      $error("table row disagrees with allocator: exp %h got %h", res, e);
      errors++;
    end
    expected_q.push_back(e);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction: %h", out_data);
          errors++;
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          if (e.out_offset != out_data.out_offset) begin
            $error("out_offset exp %h got %h", e.out_offset, out_data.out_offset);
            errors++;
          end
          if (e.out_size != out_data.out_size) begin
            $error("out_size exp %h got %h", e.out_size, out_data.out_size);
            errors++;
          end
          if (e.reused != out_data.reused) begin
            $error("reused exp %b got %b", e.reused, out_data.reused);
            errors++;
          end
          if (e.status != out_data.status) begin
            $error("status exp %d got %d", e.status, out_data.status);
            errors++;
          end
        end
      end
      out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 31);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet > 20000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic out_item_t mk(logic [39:0] o, logic [31:0] s, logic ru,
                                   logic [1:0] st);
    out_item_t r;
    r.out_offset = o;
    r.out_size = s;
    r.reused = ru;
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] rand_size(logic [16:0] g);
    case ($urandom_range(5))
      0: return $urandom_range(3) * g;
      1: return $urandom();
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom_range(6) * g + $urandom_range(2) - 1;
    endcase
  endfunction

  initial begin
    row_t rows [$];
    logic [16:0] grans [5];
    logic [39:0] starts [5];
    list_len = 0;
    gran = BlockSizeRst;
    carve_ptr = StartOffsetRst;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    rows.push_back('{KindAlloc, 32'd1, 40'hFF_FFFF_FFFF, 1, mk(0, 4096, 0, StAllocated)});
    rows.push_back('{KindAlloc, 32'd0, 40'd0, 1, mk(4096, 0, 0, StAllocated)});
    rows.push_back('{KindAlloc, 32'hFFFF_FFFF, 40'd0, 1, mk(0, 0, 0, StExhausted)});
    rows.push_back('{KindFree, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1, mk(0, 0, 0, StFreeStored)});
    rows.push_back('{KindFree, 32'd8192, 40'h12_3456_7890, 1, mk(0, 0, 0, StFreeStored)});
    rows.push_back('{KindAlloc, 32'd5000, 40'd0, 1,
                     mk(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, StAllocated)});
    rows.push_back('{KindAlloc, 32'd0, 40'd0, 1, mk(40'h12_3456_7890, 8192, 1, StAllocated)});
    rows.push_back('{KindAlloc, 32'd4097, 40'd0, 0, '0});
    for (int i = 0; i < FreeSlots; i++) begin
      rows.push_back('{KindFree, 32'd100 * i, 40'd7 * i, 1, mk(0, 0, 0, StFreeStored)});
    end
    rows.push_back('{KindFree, 32'd1, 40'd1, 1, mk(0, 0, 0, StListFull)});
    foreach (rows[k]) send(rows[k].kind, rows[k].req, rows[k].poff, rows[k].typed, rows[k].res);
    drain();

    grans = '{17'd0, 17'd1, 17'h1FFFF, 17'd65536, 17'd512};
    starts = '{40'd0, 40'hFF_FFFF_0000, 40'hFF_FFFF_FFFF, 40'h80_0000_0000, 40'd4096};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CfgBlockSize, {23'd0, grans[ph]});
      write_reg(CfgStartOffset, starts[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < 250; n++) begin
        // Keep a mix of allocates and frees so the list fills and empties.
        if ($urandom_range(99) < 45) begin
          send(KindFree, rand_size(gran[16:0] == 0 ? 17'd1 : gran),
               40'({$urandom(), $urandom()} >> 24), 0, '0);
        end else begin
          send(KindAlloc, rand_size(gran[16:0] == 0 ? 17'd1 : gran),
               40'({$urandom(), $urandom()} >> 24), 0, '0);
        end
        if (n == 100) begin
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      no_idle = 1'b0;
      drain();
      // Draining the list between phases keeps stale entries from leaking
      // into the next setting.
      while (list_len > 0) begin
        send(KindAlloc, 32'd0, 40'd0, 0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
